// ----- sv/tts_pkg.sv -----
// Shared types and constants for the touch tap and swipe detector.
// No dependencies; imported by tts_div and touch_tap_swipe_detector.
package tts_pkg;

  localparam int CFG_W   = 12;  // offset, threshold and step registers
  localparam int TMS_W   = 16;  // tap duration register
  localparam int TIME_W  = 32;
  localparam int ID_W    = 4;
  localparam int KIND_W  = 3;
  localparam int DIR_W   = 3;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 16;

  localparam logic [CFG_W-1:0] TAP_OFF_RST = 12'd10;
  localparam logic [TMS_W-1:0] TAP_MS_RST  = 16'd260;
  localparam logic [CFG_W-1:0] SWIPE_RST   = 12'd10;
  localparam logic [CFG_W-1:0] STEP_RST    = 12'd10;

  typedef enum logic [CIDX_W-1:0] {
    CFG_TAP_OFF  = 3'd0,
    CFG_TAP_MS   = 3'd1,
    CFG_SWIPE_X  = 3'd2,
    CFG_SWIPE_Y  = 3'd3,
    CFG_STEP_X   = 3'd4,
    CFG_STEP_Y   = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_PRESS   = 2'd0,
    MODE_MOVE    = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_PROCESS = 2'd3
  } mode_e;

  typedef enum logic [KIND_W-1:0] {
    EV_PRESSED  = 3'd0,
    EV_MOTION   = 3'd1,
    EV_RELEASED = 3'd2,
    EV_TAP      = 3'd3,
    EV_SWIPE_X  = 3'd4,
    EV_SWIPE_Y  = 3'd5,
    EV_SWIPE_XY = 3'd6
  } event_kind_e;

  typedef enum logic [DIR_W-1:0] {
    DIR_NONE  = 3'd0,
    DIR_DOWN  = 3'd1,
    DIR_UP    = 3'd2,
    DIR_LEFT  = 3'd3,
    DIR_RIGHT = 3'd4
  } dir_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIVX_GO,
    ST_DIVX_WAIT,
    ST_DIVY_GO,
    ST_DIVY_WAIT,
    ST_END,
    ST_FLUSH,
    ST_FLUSH_LAST
  } state_e;

  typedef struct packed {
    logic start;
    logic neg;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- sv/tts_div.sv -----
// Shared restoring divider: one quotient bit per cycle, signed result.
// Depends on tts_pkg (div_ctrl_t, div_stat_t, CFG_W).
module tts_div #(
  parameter int CW = 12
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tts_pkg::div_ctrl_t      ctrl_i,
  input  logic [CW-1:0]           mag_i,
  input  logic [tts_pkg::CFG_W-1:0] dvs_i,
  output tts_pkg::div_stat_t      stat_o,
  output logic signed [CW:0]      quot_o
);
  import tts_pkg::*;

  localparam int CNT_W = $clog2(CW + 1);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CFG_W:0]     rem_q, rem_d;
  logic [CW-1:0]      q_q, q_d;
  logic               neg_q;
  logic [CFG_W-1:0]   dvs_q;
  logic [CFG_W:0]     shifted;
  logic               ge;

  always_comb begin
    shifted = {rem_q[CFG_W-1:0], q_q[CW-1]};
    ge      = shifted >= {1'b0, dvs_q};
    rem_d   = ge ? (shifted - {1'b0, dvs_q}) : shifted;
    q_d     = {q_q[CW-2:0], ge};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(CW);
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      rem_q <= '0;
      q_q   <= mag_i;
      neg_q <= ctrl_i.neg;
      dvs_q <= dvs_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      q_q   <= q_d;
    end
  end

  // a zero step register yields zero steps
  always_comb begin
    if (dvs_q == '0) begin
      quot_o = '0;
    end else if (neg_q) begin
      quot_o = -$signed({1'b0, q_q});
    end else begin
      quot_o = $signed({1'b0, q_q});
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// ----- sv/touch_tap_swipe_detector.sv -----
// Touch tap/swipe detector. Press, move and release beats are held as a result and reach the
// output register from ST_FLUSH_LAST once the output is free. A process beat visits one slot
// per cycle while no swipe slot waits on the shared divider and no held result must first be
// flushed; a swipe slot runs the divider for X and Y in turn. Input is stalled for the whole item.
// Reset (async, low) clears slot valid and press flags and loads the register defaults; no
// clearing pass.
module touch_tap_swipe_detector #(
  parameter int NUM_SLOTS  = 10,
  parameter int COORD_BITS = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tts_pkg::CIDX_W-1:0]     cfg_idx_i,
  input  logic [tts_pkg::CDATA_W-1:0]    cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     mode_i,
  input  logic [tts_pkg::ID_W-1:0]       touch_id_i,
  input  logic [COORD_BITS-1:0]          pos_x_i,
  input  logic [COORD_BITS-1:0]          pos_y_i,
  input  logic [tts_pkg::TIME_W-1:0]     time_ms_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [tts_pkg::KIND_W-1:0]     event_kind_o,
  output logic [tts_pkg::ID_W-1:0]       slot_o,
  output logic [COORD_BITS-1:0]          at_x_o,
  output logic [COORD_BITS-1:0]          at_y_o,
  output logic [COORD_BITS-1:0]          from_x_o,
  output logic [COORD_BITS-1:0]          from_y_o,
  output logic signed [COORD_BITS:0]     delta_x_o,
  output logic signed [COORD_BITS:0]     delta_y_o,
  output logic signed [COORD_BITS:0]     steps_x_o,
  output logic signed [COORD_BITS:0]     steps_y_o,
  output logic [tts_pkg::DIR_W-1:0]      direction_o,
  output logic                           last_o
);
  import tts_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int MW = ((CW > CFG_W) ? CW : CFG_W) + 1;

  // configuration
  logic [CFG_W-1:0] tap_off_q, swipe_x_q, swipe_y_q, step_x_q, step_y_q;
  logic [TMS_W-1:0] tap_ms_q;

  // slot store
  logic [NUM_SLOTS-1:0] valid_q, pdone_q;
  logic [TIME_W-1:0]    ptime_q [NUM_SLOTS];
  logic [TIME_W-1:0]    rtime_q [NUM_SLOTS];
  logic [CW-1:0]        first_x_q [NUM_SLOTS];
  logic [CW-1:0]        first_y_q [NUM_SLOTS];
  logic [CW-1:0]        start_x_q [NUM_SLOTS];
  logic [CW-1:0]        start_y_q [NUM_SLOTS];
  logic [CW-1:0]        end_x_q [NUM_SLOTS];
  logic [CW-1:0]        end_y_q [NUM_SLOTS];
  logic [CW-1:0]        base_x_q [NUM_SLOTS];
  logic [CW-1:0]        base_y_q [NUM_SLOTS];

  state_e state_q, state_d;
  logic [SW-1:0] idx_q;

  // held result
  logic               res_pend_q;
  event_kind_e        res_kind_q;
  logic [ID_W-1:0]    res_slot_q;
  logic [CW-1:0]      res_at_x_q, res_at_y_q, res_from_x_q, res_from_y_q;
  logic signed [CW:0] res_dx_q, res_dy_q, res_sx_q, res_sy_q;
  dir_e               res_dir_q;
  logic signed [CW:0] ox_q, oy_q;

  // output register
  logic               out_vld_q;
  event_kind_e        out_kind_q;
  logic [ID_W-1:0]    out_slot_q;
  logic [CW-1:0]      out_at_x_q, out_at_y_q, out_from_x_q, out_from_y_q;
  logic signed [CW:0] out_dx_q, out_dy_q, out_sx_q, out_sy_q;
  dir_e               out_dir_q;
  logic               out_last_q;

  // divider
  div_ctrl_t          div_ctrl;
  div_stat_t          div_stat;
  logic [CW-1:0]      div_mag;
  logic [CFG_W-1:0]   div_dvs;
  logic signed [CW:0] div_quot;

  // control
  logic in_acc, out_free, id_ok, is_last, slot_adv, do_flush, scan_upd;
  logic [SW-1:0] wid;
  mode_e in_mode;

  // per-slot evaluation
  logic [TIME_W-1:0]  dur;
  logic               tap_time, tap_ok, fx, fy, hit;
  logic signed [CW:0] dfx, dfy, ox, oy;
  logic [CW:0]        adx, ady, aox, aoy, sum_x, sum_y;
  logic [CW-1:0]      s_end_x, s_end_y, s_start_x, s_start_y;
  dir_e               sw_dir;
  event_kind_e        sw_kind;

  assign in_mode  = mode_e'(mode_i);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_vld_q || !out_stall_i;
  assign id_ok    = {1'b0, touch_id_i} < 5'(NUM_SLOTS);
  assign wid      = touch_id_i[SW-1:0];
  assign is_last  = idx_q == SW'(NUM_SLOTS - 1);

  always_comb begin
    s_end_x   = end_x_q[idx_q];
    s_end_y   = end_y_q[idx_q];
    s_start_x = start_x_q[idx_q];
    s_start_y = start_y_q[idx_q];
    dur       = rtime_q[idx_q] - ptime_q[idx_q];
    tap_time  = $signed(dur) < $signed({{(TIME_W - TMS_W){1'b0}}, tap_ms_q});
    dfx = $signed({1'b0, s_end_x}) - $signed({1'b0, first_x_q[idx_q]});
    dfy = $signed({1'b0, s_end_y}) - $signed({1'b0, first_y_q[idx_q]});
    ox  = $signed({1'b0, s_end_x}) - $signed({1'b0, base_x_q[idx_q]});
    oy  = $signed({1'b0, s_end_y}) - $signed({1'b0, base_y_q[idx_q]});
    adx = dfx[CW] ? -dfx : dfx;
    ady = dfy[CW] ? -dfy : dfy;
    aox = ox[CW] ? -ox : ox;
    aoy = oy[CW] ? -oy : oy;
    tap_ok = pdone_q[idx_q] && tap_time
             && (MW'(adx) <= MW'(tap_off_q)) && (MW'(ady) <= MW'(tap_off_q));
    fx  = MW'(aox) >= MW'(swipe_x_q);
    fy  = MW'(aoy) >= MW'(swipe_y_q);
    hit = valid_q[idx_q] && (tap_ok || fx || fy);
    sum_x = {1'b0, first_x_q[idx_q]} + {1'b0, s_end_x};
    sum_y = {1'b0, first_y_q[idx_q]} + {1'b0, s_end_y};
    if (fx) begin
      sw_dir = ox[CW] ? DIR_LEFT : DIR_RIGHT;
    end else if (fy) begin
      sw_dir = oy[CW] ? DIR_UP : DIR_DOWN;
    end else begin
      sw_dir = DIR_NONE;
    end
    if (fx && fy) begin
      sw_kind = EV_SWIPE_XY;
    end else if (fx) begin
      sw_kind = EV_SWIPE_X;
    end else begin
      sw_kind = EV_SWIPE_Y;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_mode == MODE_PROCESS) begin
            state_d = ST_SCAN;
          end else if (id_ok) begin
            state_d = ST_FLUSH_LAST;
          end
        end
      end
      ST_SCAN: begin
        if (hit && res_pend_q) begin
          state_d = ST_FLUSH;
        end else if (valid_q[idx_q] && !tap_ok && (fx || fy)) begin
          state_d = ST_DIVX_GO;
        end else begin
          state_d = is_last ? ST_END : ST_SCAN;
        end
      end
      ST_DIVX_GO:   state_d = ST_DIVX_WAIT;
      ST_DIVX_WAIT: if (div_stat.done) state_d = ST_DIVY_GO;
      ST_DIVY_GO:   state_d = ST_DIVY_WAIT;
      ST_DIVY_WAIT: if (div_stat.done) state_d = is_last ? ST_END : ST_SCAN;
      ST_END:       state_d = res_pend_q ? ST_FLUSH_LAST : ST_IDLE;
      ST_FLUSH:     if (out_free) state_d = ST_SCAN;
      ST_FLUSH_LAST: if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o   = state_q != ST_IDLE;
    do_flush     = (state_q == ST_FLUSH || state_q == ST_FLUSH_LAST) && out_free;
    scan_upd     = (state_q == ST_SCAN) && valid_q[idx_q] && !(hit && res_pend_q);
    slot_adv     = ((state_q == ST_SCAN) && !(hit && res_pend_q)
                    && !(valid_q[idx_q] && !tap_ok && (fx || fy)))
                   || ((state_q == ST_DIVY_WAIT) && div_stat.done);
    div_ctrl.start = (state_q == ST_DIVX_GO) || (state_q == ST_DIVY_GO);
    div_ctrl.neg   = (state_q == ST_DIVY_GO) ? oy_q[CW] : ox_q[CW];
    if (state_q == ST_DIVY_GO) begin
      div_mag = oy_q[CW] ? CW'(-oy_q) : CW'(oy_q);
      div_dvs = step_y_q;
    end else begin
      div_mag = ox_q[CW] ? CW'(-ox_q) : CW'(ox_q);
      div_dvs = step_x_q;
    end
  end

  tts_div #(.CW(CW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .mag_i  (div_mag),
    .dvs_i  (div_dvs),
    .stat_o (div_stat),
    .quot_o (div_quot)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      res_pend_q <= 1'b0;
      out_vld_q  <= 1'b0;
      valid_q    <= '0;
      pdone_q    <= '0;
      tap_off_q  <= TAP_OFF_RST;
      tap_ms_q   <= TAP_MS_RST;
      swipe_x_q  <= SWIPE_RST;
      swipe_y_q  <= SWIPE_RST;
      step_x_q   <= STEP_RST;
      step_y_q   <= STEP_RST;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TAP_OFF: tap_off_q <= cfg_wdata_i[CFG_W-1:0];
          CFG_TAP_MS:  tap_ms_q  <= cfg_wdata_i[TMS_W-1:0];
          CFG_SWIPE_X: swipe_x_q <= cfg_wdata_i[CFG_W-1:0];
          CFG_SWIPE_Y: swipe_y_q <= cfg_wdata_i[CFG_W-1:0];
          CFG_STEP_X:  step_x_q  <= cfg_wdata_i[CFG_W-1:0];
          CFG_STEP_Y:  step_y_q  <= cfg_wdata_i[CFG_W-1:0];
          default: ;
        endcase
      end
      if (do_flush) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      if (in_acc && in_mode == MODE_PROCESS) begin
        idx_q <= '0;
      end else if (slot_adv) begin
        idx_q <= idx_q + 1'b1;
      end
      if (do_flush) begin
        res_pend_q <= 1'b0;
      end else if (in_acc && in_mode != MODE_PROCESS && id_ok) begin
        res_pend_q <= 1'b1;
      end else if (scan_upd && (tap_ok || fx || fy)) begin
        res_pend_q <= 1'b1;
      end
      if (in_acc && in_mode != MODE_PROCESS && id_ok) begin
        if (in_mode == MODE_PRESS && touch_id_i == '0) begin
          // only slot 0 survives a press on id 0
          valid_q <= NUM_SLOTS'(1);
          pdone_q <= '0;
        end else begin
          valid_q[wid] <= 1'b1;
          if (in_mode == MODE_RELEASE) begin
            pdone_q[wid] <= 1'b1;
          end else if (!valid_q[wid]) begin
            pdone_q[wid] <= 1'b0;
          end
        end
      end else if (scan_upd) begin
        pdone_q[idx_q] <= 1'b0;
      end
    end
  end

  // slot payload; a slot touched while not valid starts from zero
  logic fresh;
  assign fresh = !valid_q[wid] || (in_mode == MODE_PRESS && touch_id_i == '0);

  always_ff @(posedge clk_i) begin
    if (in_acc && in_mode != MODE_PROCESS && id_ok) begin
      end_x_q[wid] <= pos_x_i;
      end_y_q[wid] <= pos_y_i;
      case (in_mode)
        MODE_PRESS: begin
          ptime_q[wid]   <= time_ms_i;
          first_x_q[wid] <= pos_x_i;
          first_y_q[wid] <= pos_y_i;
          start_x_q[wid] <= pos_x_i;
          start_y_q[wid] <= pos_y_i;
          base_x_q[wid]  <= pos_x_i;
          base_y_q[wid]  <= pos_y_i;
          if (fresh) rtime_q[wid] <= '0;
        end
        MODE_RELEASE: begin
          rtime_q[wid]   <= time_ms_i;
          start_x_q[wid] <= pos_x_i;
          start_y_q[wid] <= pos_y_i;
          base_x_q[wid]  <= pos_x_i;
          base_y_q[wid]  <= pos_y_i;
          if (fresh) begin
            ptime_q[wid]   <= '0;
            first_x_q[wid] <= '0;
            first_y_q[wid] <= '0;
          end
        end
        default: begin
          if (fresh) begin
            ptime_q[wid]   <= '0;
            rtime_q[wid]   <= '0;
            first_x_q[wid] <= '0;
            first_y_q[wid] <= '0;
            start_x_q[wid] <= '0;
            start_y_q[wid] <= '0;
            base_x_q[wid]  <= '0;
            base_y_q[wid]  <= '0;
          end
        end
      endcase
    end else if (scan_upd) begin
      start_x_q[idx_q] <= s_end_x;
      start_y_q[idx_q] <= s_end_y;
      if (pdone_q[idx_q]) begin
        ptime_q[idx_q] <= '0;
        rtime_q[idx_q] <= '0;
      end
      if (!tap_ok && (fx || fy)) begin
        base_x_q[idx_q] <= s_end_x;
        base_y_q[idx_q] <= s_end_y;
      end
    end
  end

  // held result and output register payload
  always_ff @(posedge clk_i) begin
    if (in_acc && in_mode != MODE_PROCESS && id_ok) begin
      res_kind_q   <= event_kind_e'({1'b0, mode_i});
      res_slot_q   <= touch_id_i;
      res_at_x_q   <= pos_x_i;
      res_at_y_q   <= pos_y_i;
      res_from_x_q <= '0;
      res_from_y_q <= '0;
      res_dx_q     <= '0;
      res_dy_q     <= '0;
      res_sx_q     <= '0;
      res_sy_q     <= '0;
      res_dir_q    <= DIR_NONE;
    end else if (scan_upd && tap_ok) begin
      res_kind_q   <= EV_TAP;
      res_slot_q   <= ID_W'(idx_q);
      res_at_x_q   <= sum_x[CW:1];
      res_at_y_q   <= sum_y[CW:1];
      res_from_x_q <= '0;
      res_from_y_q <= '0;
      res_dx_q     <= '0;
      res_dy_q     <= '0;
      res_sx_q     <= '0;
      res_sy_q     <= '0;
      res_dir_q    <= DIR_NONE;
    end else if (scan_upd && (fx || fy)) begin
      res_kind_q   <= sw_kind;
      res_slot_q   <= ID_W'(idx_q);
      res_at_x_q   <= s_end_x;
      res_at_y_q   <= s_end_y;
      res_from_x_q <= s_start_x;
      res_from_y_q <= s_start_y;
      res_dx_q     <= $signed({1'b0, s_end_x}) - $signed({1'b0, s_start_x});
      res_dy_q     <= $signed({1'b0, s_end_y}) - $signed({1'b0, s_start_y});
      res_dir_q    <= sw_dir;
      ox_q         <= ox;
      oy_q         <= oy;
    end
    if (state_q == ST_DIVX_WAIT && div_stat.done) begin
      res_sx_q <= div_quot;
    end
    if (state_q == ST_DIVY_WAIT && div_stat.done) begin
      res_sy_q <= div_quot;
    end
    if (do_flush) begin
      out_kind_q   <= res_kind_q;
      out_slot_q   <= res_slot_q;
      out_at_x_q   <= res_at_x_q;
      out_at_y_q   <= res_at_y_q;
      out_from_x_q <= res_from_x_q;
      out_from_y_q <= res_from_y_q;
      out_dx_q     <= res_dx_q;
      out_dy_q     <= res_dy_q;
      out_sx_q     <= res_sx_q;
      out_sy_q     <= res_sy_q;
      out_dir_q    <= res_dir_q;
      out_last_q   <= state_q == ST_FLUSH_LAST;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign event_kind_o = out_kind_q;
  assign slot_o       = out_slot_q;
  assign at_x_o       = out_at_x_q;
  assign at_y_o       = out_at_y_q;
  assign from_x_o     = out_from_x_q;
  assign from_y_o     = out_from_y_q;
  assign delta_x_o    = out_dx_q;
  assign delta_y_o    = out_dy_q;
  assign steps_x_o    = out_sx_q;
  assign steps_y_o    = out_sy_q;
  assign direction_o  = out_dir_q;
  assign last_o       = out_last_q;

`ifndef SYNTHESIS
  // divider finishes only while the sequencer waits on it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_DIVX_WAIT || state_q == ST_DIVY_WAIT))
    else $error("divider done outside a wait state");

  // a new result is never built over one that has not been flushed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_pend_q && state_q == ST_SCAN) |=> (res_pend_q || $past(do_flush)))
    else $error("held result lost during scan");

  // taps and echoes carry no direction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_kind_q == EV_TAP || out_kind_q == EV_PRESSED
      || out_kind_q == EV_MOTION || out_kind_q == EV_RELEASED))
    |-> (out_dir_q == DIR_NONE))
    else $error("direction set on a non-swipe beat");
`endif

endmodule
